[hw/rtl/mco_pkg.sv]
// mco_pkg: shared types, sizes, token codes and saturating helpers
// for the matrix chain ordering block; depends on nothing
package mco_pkg;

	localparam int MAX_MATRICES = 16;
	localparam int DIM_BITS = 12;
	localparam int FIELD_DIM_W = 12;
	localparam int COST_W = 40;
	localparam int IDX_W = $clog2(MAX_MATRICES);
	localparam int CNT_W = $clog2(MAX_MATRICES + 1);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int PROD1_W = 2 * DIM_BITS;
	localparam int PROD_W = 3 * DIM_BITS;

	typedef logic [DIM_BITS-1:0] dim_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [COST_W-1:0] cost_t;

	localparam cost_t COST_MAX = {COST_W{1'b1}};

	typedef enum logic [1:0] {
		TOK_COST  = 2'd0,
		TOK_OPEN  = 2'd1,
		TOK_MATRIX = 2'd2,
		TOK_CLOSE = 2'd3
	} tok_t;

	typedef struct packed {
		logic [FIELD_DIM_W-1:0] row_count;
		logic [FIELD_DIM_W-1:0] col_count;
		logic final_matrix;
	} in_item_t;

	typedef struct packed {
		logic [1:0] token_kind;
		logic [4:0] matrix_number;
		cost_t total_cost;
		logic dropped_items;
		logic last_token;
	} out_item_t;

	// dimension store write from the load side
	typedef struct packed {
		logic en;
		idx_t addr;
		dim_t rows;
		dim_t cols;
	} ld_wr_t;

	// chain control from the top level
	typedef struct packed {
		logic go;
		cnt_t cnt;
		logic ovf;
	} chain_ctl_t;

	function automatic cost_t sat_add(cost_t a, cost_t b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction

	function automatic cost_t sat_prod(logic [PROD_W-1:0] p);
		logic [PROD_W+COST_W-1:0] w;
		logic [PROD_W+COST_W-1:0] lim;
		w = {{COST_W{1'b0}}, p};
		lim = {{PROD_W{1'b0}}, COST_MAX};
		return (w > lim) ? COST_MAX : w[COST_W-1:0];
	endfunction

endpackage

[hw/rtl/mco_dp.sv]
// mco_dp: dimension stores, cost and split tables, and the diagonal
// dynamic program sequencer; depends on mco_pkg
module mco_dp import mco_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ld_wr_t     ld_wr,
	input  chain_ctl_t ctl,
	input  addr_t      emit_cost_addr,
	input  addr_t      emit_split_addr,
	output cost_t      cost_rd,
	output idx_t       split_rd,
	output logic       done
);

	typedef enum logic [2:0] {
		D_IDLE, D_INIT, D_PAIR, D_PAIR2, D_RD, D_MUL1, D_MUL2, D_ADD
	} dstate_t;

	dstate_t state_q;
	idx_t d_q, i_q, k_q;
	cnt_t cnt_q;
	dim_t row_i_q, col_j_q;
	cost_t best_q;
	idx_t best_k_q;
	logic done_q;

	logic [PROD1_W-1:0] prod1_s1;
	cost_t sum_s1;
	cost_t term_s2;

	dim_t row_mem [MAX_MATRICES];
	dim_t col_mem [MAX_MATRICES];
	cost_t cost_mem [1 << ADDR_W];
	idx_t split_mem [1 << ADDR_W];

	dim_t row_rd, col_rd;
	cost_t cost_b_rd;

	idx_t j;
	idx_t col_addr;
	addr_t cost_a_addr, cost_b_addr;
	logic [PROD_W-1:0] prod_full;
	cost_t cand;
	logic take;
	cost_t new_best;
	idx_t new_k;
	logic wr_en;
	addr_t wr_addr;
	cost_t wr_cost;
	idx_t wr_split;

	assign j = i_q + d_q;
	assign col_addr = (state_q == D_PAIR) ? j : k_q;
	assign cost_a_addr = (state_q == D_IDLE) ? emit_cost_addr : {i_q, k_q};
	assign cost_b_addr = {idx_t'(k_q + 1'b1), j};

	// candidate cost for the current split point
	assign prod_full = prod1_s1 * col_j_q;
	assign cand = sat_add(sum_s1, term_s2);
	assign take = (k_q == i_q) || (cand < best_q);
	assign new_best = take ? cand : best_q;
	assign new_k = take ? k_q : best_k_q;

	// table write: diagonal init or end of a split scan
	always_comb begin
		wr_en = 1'b0;
		wr_addr = {i_q, j};
		wr_cost = new_best;
		wr_split = new_k;
		if (state_q == D_INIT) begin
			wr_en = 1'b1;
			wr_addr = {i_q, i_q};
			wr_cost = '0;
			wr_split = i_q;
		end else if (state_q == D_ADD && k_q == idx_t'(j - 1'b1)) begin
			wr_en = 1'b1;
		end
	end

	// dimension stores
	always_ff @(posedge clk) begin
		if (ld_wr.en) begin
			row_mem[ld_wr.addr] <= ld_wr.rows;
			col_mem[ld_wr.addr] <= ld_wr.cols;
		end
		row_rd <= row_mem[i_q];
		col_rd <= col_mem[col_addr];
	end

	// cost and split tables
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cost_mem[wr_addr] <= wr_cost;
			split_mem[wr_addr] <= wr_split;
		end
		cost_rd <= cost_mem[cost_a_addr];
		cost_b_rd <= cost_mem[cost_b_addr];
		split_rd <= split_mem[emit_split_addr];
	end

	// arithmetic pipeline registers
	always_ff @(posedge clk) begin
		if (state_q == D_MUL1) begin
			prod1_s1 <= row_i_q * col_rd;
			sum_s1 <= sat_add(cost_rd, cost_b_rd);
		end
		if (state_q == D_MUL2) begin
			term_s2 <= sat_prod(prod_full);
		end
	end

	// sequencer over diagonals, pairs and split points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			d_q <= '0;
			i_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
			row_i_q <= '0;
			col_j_q <= '0;
			best_q <= '0;
			best_k_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (ctl.go) begin
						cnt_q <= ctl.cnt;
						i_q <= '0;
						state_q <= D_INIT;
					end
				end
				D_INIT: begin
					if (cnt_t'(i_q) + 1'b1 < cnt_q) begin
						i_q <= i_q + 1'b1;
					end else if (cnt_q > cnt_t'(1)) begin
						i_q <= '0;
						d_q <= idx_t'(1);
						state_q <= D_PAIR;
					end else begin
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				D_PAIR: state_q <= D_PAIR2;
				D_PAIR2: begin
					row_i_q <= row_rd;
					col_j_q <= col_rd;
					k_q <= i_q;
					state_q <= D_RD;
				end
				D_RD: state_q <= D_MUL1;
				D_MUL1: state_q <= D_MUL2;
				D_MUL2: state_q <= D_ADD;
				D_ADD: begin
					best_q <= new_best;
					best_k_q <= new_k;
					if (k_q == idx_t'(j - 1'b1)) begin
						if (cnt_t'(j) + 1'b1 < cnt_q) begin
							i_q <= i_q + 1'b1;
							state_q <= D_PAIR;
						end else if (cnt_t'(d_q) + 1'b1 < cnt_q) begin
							d_q <= d_q + 1'b1;
							i_q <= '0;
							state_q <= D_PAIR;
						end else begin
							done_q <= 1'b1;
							state_q <= D_IDLE;
						end
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= D_RD;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;

endmodule

[hw/rtl/mco_emit.sv]
// mco_emit: walks the split table once per matrix and emits the total
// cost and the parenthesization words; depends on mco_pkg
module mco_emit import mco_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	input  logic       start_emit,
	input  cost_t      cost_rd,
	input  idx_t       split_rd,
	output addr_t      cost_addr,
	output addr_t      split_addr,
	output logic       result_strobe,
	output out_item_t  result
);

	typedef enum logic [2:0] {
		E_IDLE, E_COST, E_COSTOUT, E_WALK, E_WAIT, E_OPEN, E_CLOSE
	} estate_t;

	estate_t state_q;
	idx_t m_q, lo_q, hi_q;
	cnt_t opens_q, closes_q;
	logic strobe_q;
	out_item_t result_q;

	idx_t last_idx;
	logic last_m;

	assign last_idx = idx_t'(ctl.cnt - 1'b1);
	assign last_m = (m_q == last_idx);
	assign cost_addr = {idx_t'(0), last_idx};
	assign split_addr = {lo_q, hi_q};

	// token sequencer: per matrix, opens, the matrix, then closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			m_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			opens_q <= '0;
			closes_q <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			result_q <= '0;
			result_q.dropped_items <= ctl.ovf;
			case (state_q)
				E_IDLE: begin
					if (start_emit) begin
						state_q <= E_COST;
					end
				end
				E_COST: state_q <= E_COSTOUT;
				E_COSTOUT: begin
					strobe_q <= 1'b1;
					result_q.token_kind <= TOK_COST;
					result_q.total_cost <= cost_rd;
					m_q <= '0;
					lo_q <= '0;
					hi_q <= last_idx;
					opens_q <= '0;
					closes_q <= '0;
					state_q <= E_WALK;
				end
				E_WALK: begin
					if (lo_q == hi_q) begin
						state_q <= E_OPEN;
					end else begin
						if (lo_q == m_q) opens_q <= opens_q + 1'b1;
						if (hi_q == m_q) closes_q <= closes_q + 1'b1;
						state_q <= E_WAIT;
					end
				end
				E_WAIT: begin
					if (m_q <= split_rd) begin
						hi_q <= split_rd;
					end else begin
						lo_q <= split_rd + 1'b1;
					end
					state_q <= E_WALK;
				end
				E_OPEN: begin
					strobe_q <= 1'b1;
					if (opens_q != '0) begin
						result_q.token_kind <= TOK_OPEN;
						opens_q <= opens_q - 1'b1;
					end else begin
						result_q.token_kind <= TOK_MATRIX;
						result_q.matrix_number <= 5'(m_q);
						if (closes_q != '0) begin
							state_q <= E_CLOSE;
						end else if (last_m) begin
							result_q.last_token <= 1'b1;
							state_q <= E_IDLE;
						end else begin
							m_q <= m_q + 1'b1;
							lo_q <= '0;
							hi_q <= last_idx;
							state_q <= E_WALK;
						end
					end
				end
				E_CLOSE: begin
					strobe_q <= 1'b1;
					result_q.token_kind <= TOK_CLOSE;
					closes_q <= closes_q - 1'b1;
					if (closes_q == cnt_t'(1)) begin
						if (last_m) begin
							result_q.last_token <= 1'b1;
							state_q <= E_IDLE;
						end else begin
							m_q <= m_q + 1'b1;
							lo_q <= '0;
							hi_q <= last_idx;
							opens_q <= '0;
							state_q <= E_WALK;
						end
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign result = result_q;

endmodule

[hw/rtl/matrix_chain_order.sv]
// matrix_chain_order: loads one dimension pair per cycle (one word per cycle while not busy).
// After the final word, busy stays high while the tables fill and over the walk:
// pairs set up in D_PAIR and D_PAIR2, each split point goes D_RD, D_MUL1, D_MUL2, D_ADD.
// Results come one per cycle after the walk of each matrix, up to 47 words, one-cycle strobe.
// Reset clears the load count, the overflow flag and all sequencers; tables need no clearing.
// The receiver cannot stall; busy drops after the strobe of the last word.
module matrix_chain_order import mco_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      result_strobe,
	output out_item_t result
);

	logic busy_q;
	cnt_t count_q;
	logic ovf_q;
	logic go_q;
	cnt_t chain_cnt_q;
	logic chain_ovf_q;

	logic accept;
	logic room;
	ld_wr_t ld_wr;
	chain_ctl_t ctl;
	logic dp_done;
	cost_t cost_rd;
	idx_t split_rd;
	addr_t emit_cost_addr, emit_split_addr;

	assign accept = start && !busy_q;
	assign room = (count_q < cnt_t'(MAX_MATRICES));

	assign ld_wr.en = accept && room;
	assign ld_wr.addr = idx_t'(count_q);
	assign ld_wr.rows = item.row_count[DIM_BITS-1:0];
	assign ld_wr.cols = item.col_count[DIM_BITS-1:0];

	assign ctl.go = go_q;
	assign ctl.cnt = chain_cnt_q;
	assign ctl.ovf = chain_ovf_q;

	// load count, overflow flag and busy control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
			ovf_q <= 1'b0;
			go_q <= 1'b0;
			chain_cnt_q <= '0;
			chain_ovf_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (accept) begin
				if (item.final_matrix) begin
					busy_q <= 1'b1;
					go_q <= 1'b1;
					chain_cnt_q <= room ? count_q + 1'b1 : count_q;
					chain_ovf_q <= ovf_q || !room;
					count_q <= '0;
					ovf_q <= 1'b0;
				end else if (room) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (result_strobe && result.last_token) begin
				busy_q <= 1'b0;
			end
		end
	end

	mco_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ld_wr           (ld_wr),
		.ctl             (ctl),
		.emit_cost_addr  (emit_cost_addr),
		.emit_split_addr (emit_split_addr),
		.cost_rd         (cost_rd),
		.split_rd        (split_rd),
		.done            (dp_done)
	);

	mco_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.start_emit    (dp_done),
		.cost_rd       (cost_rd),
		.split_rd      (split_rd),
		.cost_addr     (emit_cost_addr),
		.split_addr    (emit_split_addr),
		.result_strobe (result_strobe),
		.result        (result)
	);

	assign busy = busy_q;

endmodule
